/* hdl/cwp_pkg.sv */
package cwp_pkg;

  // Command opcodes found in the top byte of a command word.
  localparam logic [7:0] OP_FLAT_QUAD   = 8'h28;
  localparam logic [7:0] OP_TEX_QUAD    = 8'h2c;
  localparam logic [7:0] OP_SHADED_TRI  = 8'h30;
  localparam logic [7:0] OP_SHADED_QUAD = 8'h38;
  localparam logic [7:0] OP_HOST_TO_MEM = 8'ha0;
  localparam logic [7:0] OP_MEM_TO_HOST = 8'hc0;
  localparam logic [7:0] OP_DRAW_OFFSET = 8'he5;

  // Action codes on the input channel.
  localparam logic [1:0] ACT_WORD     = 2'd0;
  localparam logic [1:0] ACT_PULL     = 2'd1;
  localparam logic [1:0] ACT_STATUS   = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_OFFSET = 2'd2;

  localparam logic [31:0] STATUS_WORD = 32'h1c00_0000;

  // Class of an accepted item, as decided by the front end.
  typedef enum logic [1:0] {
    CLS_WORD,
    CLS_PULL,
    CLS_STATUS
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [31:0] data;
  } q_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  u;
    logic [7:0]  v;
  } vertex_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  tex_u;
    logic [7:0]  tex_v;
    logic [15:0] palette_index;
    logic [15:0] page_index;
    logic        last;
  } res_t;

endpackage

/* hdl/cwp_if.sv */
// Input channel: action and data words.
interface cwp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] data;

  modport source (output valid, action, data, input ready);
  modport sink (input valid, action, data, output ready);
endinterface

// Result channel.
interface cwp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] word;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  tex_u;
  logic [7:0]  tex_v;
  logic [15:0] palette_index;
  logic [15:0] page_index;
  logic        last;

  modport source (output valid, kind, word, pos_x, pos_y, red, green, blue, tex_u, tex_v,
                  palette_index, page_index, last, input ready);
  modport sink (input valid, kind, word, pos_x, pos_y, red, green, blue, tex_u, tex_v,
                palette_index, page_index, last, output ready);
endinterface

/* hdl/cwp_front.sv */
module cwp_front
  import cwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cwp_in_if.sink     in_ch,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  q_item_t    q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cls_t       cls;

  // Classify the incoming action; unused action codes are dropped.
  always_comb begin
    unique case (in_ch.action)
      ACT_PULL:   cls = CLS_PULL;
      ACT_STATUS: cls = CLS_STATUS;
      default:    cls = CLS_WORD;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready && (in_ch.action != ACT_RESERVED);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rd_ptr_r];

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r].cls  <= cls;
        q_r[wr_ptr_r].data <= in_ch.data;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

/* hdl/cwp_back.sv */
module cwp_back
  import cwp_pkg::*;
#(
  parameter int ROW_PIXELS   = 1024,
  parameter int ROWS         = 512,
  parameter int MAX_VERTICES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_item_t    q_item,
  output logic       q_pop,
  cwp_out_if.source  out_ch
);

  localparam int STORE = ROW_PIXELS * ROWS;
  localparam int AW    = $clog2(STORE);
  localparam int VW    = 16 + $clog2(ROW_PIXELS + 1);
  localparam int VIW   = $clog2(MAX_VERTICES);
  localparam logic [VW-1:0] STORE_V   = VW'(STORE);
  localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / 64'(STORE));
  localparam logic [AW-1:0] STORE_TOP = AW'(STORE - 1);
  localparam logic [4:0]    NV        = 5'(MAX_VERTICES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_SIZE,
    S_MOD,
    S_SUB,
    S_FIX,
    S_MEM0,
    S_MEM1,
    S_MEM2
  } state_t;

  state_t          st_r;
  logic            busy_r;
  logic [7:0]      op_r;
  logic [3:0]      phase_r;
  logic [2:0]      tvi_r;
  vertex_t         vs_r [MAX_VERTICES];
  logic [15:0]     pal_r;
  logic [15:0]     page_r;
  logic [15:0]     origin_r;
  logic [15:0]     width_r;
  logic [15:0]     walk_x_r;
  logic [15:0]     walk_y_r;
  logic [31:0]     words_r;
  logic [31:0]     area_r;
  logic [31:0]     cur_data_r;
  logic            wr_r;
  logic [VW-1:0]   val_r;
  logic [VW-1:0]   quo_r;
  logic [VW-1:0]   diff_r;
  logic [AW-1:0]   rem_r;
  logic [15:0]     hi_r;
  logic [VIW-1:0]  em_idx_r;
  logic [VIW-1:0]  em_last_r;
  logic            em_tex_r;
  res_t            out_r;
  logic            out_vld_r;

  logic [15:0]     pix_r [STORE];
  logic [15:0]     mem_q_r;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic [15:0]     mem_wd;

  logic            out_free;
  logic [31:0]     d;
  logic [7:0]      eff_op;
  logic [3:0]      eff_phase;
  logic [4:0]      ph_inc;
  logic [3:0]      ph_m1;
  logic [4:0]      nvert;
  logic            is_poly_new;
  logic            is_xfer_new;
  logic            xfer_busy;
  logic            read_live;
  logic [VW+31:0]  prod;
  logic [VW-1:0]   quo_store;
  logic [AW-1:0]   addr_next;
  logic [15:0]     wx_add;
  logic            row_wrap;
  logic [31:0]     words_dec;
  logic [31:0]     words_init;
  logic [VW-1:0]   lin_addr;
  vertex_t         em_v;

  assign out_free = !out_vld_r || out_ch.ready;
  assign q_pop    = (st_r == S_IDLE) && q_valid && out_free;
  assign d        = q_item.data;

  // Polygon decode: a new command starts at phase zero.
  assign is_poly_new = (d[31:24] == OP_FLAT_QUAD) || (d[31:24] == OP_TEX_QUAD) ||
                       (d[31:24] == OP_SHADED_TRI) || (d[31:24] == OP_SHADED_QUAD);
  assign is_xfer_new = (d[31:24] == OP_HOST_TO_MEM) || (d[31:24] == OP_MEM_TO_HOST);
  assign xfer_busy   = (op_r == OP_HOST_TO_MEM) || (op_r == OP_MEM_TO_HOST);
  assign eff_op      = busy_r ? op_r : d[31:24];
  assign eff_phase   = busy_r ? phase_r : 4'd0;
  assign ph_inc      = {1'b0, eff_phase} + 5'd1;
  assign ph_m1       = eff_phase - 4'd1;
  assign nvert       = (eff_op == OP_SHADED_TRI) ? 5'd3 : NV;
  assign read_live   = busy_r && (op_r == OP_MEM_TO_HOST) && (phase_r >= 4'd2) &&
                       (words_r != 32'd0);

  // Pixel address arithmetic and the rectangle walk. The quotient estimate by
  // the scaled reciprocal is low by at most one, so one correction step follows.
  assign lin_addr   = VW'(walk_y_r) * VW'(ROW_PIXELS) + VW'(walk_x_r);
  assign prod       = {32'd0, val_r} * {{VW{1'b0}}, RECIP};
  assign quo_store  = quo_r * STORE_V;
  assign addr_next  = (rem_r == STORE_TOP) ? '0 : rem_r + AW'(1);
  assign wx_add     = walk_x_r + 16'd2;
  assign row_wrap   = ({1'b0, wx_add} >= ({1'b0, origin_r} + {1'b0, width_r}));
  assign words_dec  = words_r - 32'd1;
  assign words_init = {1'b0, area_r[31:1]} + {31'd0, area_r[0]};
  assign em_v       = vs_r[em_idx_r];

  // Pixel store port.
  always_comb begin
    mem_addr = (st_r == S_MEM1) ? addr_next : rem_r;
    mem_we   = wr_r && ((st_r == S_MEM0) || (st_r == S_MEM1));
    mem_wd   = (st_r == S_MEM0) ? cur_data_r[15:0] : cur_data_r[31:16];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_r[mem_addr] <= mem_wd;
    end
    mem_q_r <= pix_r[mem_addr];
  end

  // Control, vertex store and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      busy_r    <= 1'b0;
      op_r      <= 8'd0;
      phase_r   <= 4'd0;
      tvi_r     <= 3'd0;
      pal_r     <= 16'd0;
      page_r    <= 16'd0;
      origin_r  <= 16'd0;
      width_r   <= 16'd0;
      walk_x_r  <= 16'd0;
      walk_y_r  <= 16'd0;
      words_r   <= 32'd0;
      out_vld_r <= 1'b0;
      wr_r      <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        vs_r[i] <= '0;
      end
    end else begin
      if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.cls)
              CLS_STATUS: begin
                out_r       <= '0;
                out_r.kind  <= KIND_WORD;
                out_r.word  <= STATUS_WORD;
                out_r.last  <= 1'b1;
                out_vld_r   <= 1'b1;
              end
              CLS_PULL: begin
                if (read_live) begin
                  wr_r  <= 1'b0;
                  val_r <= lin_addr;
                  rem_r <= '0;
                  st_r  <= S_MOD;
                end else begin
                  out_r      <= '0;
                  out_r.kind <= KIND_WORD;
                  out_r.last <= 1'b1;
                  out_vld_r  <= 1'b1;
                end
              end
              default: begin
                if (busy_r && xfer_busy) begin
                  // Rectangle transfer parameter or pixel word.
                  if (phase_r == 4'd0) begin
                    origin_r <= d[15:0];
                    walk_x_r <= d[15:0];
                    walk_y_r <= d[31:16];
                    phase_r  <= 4'd1;
                  end else if (phase_r == 4'd1) begin
                    width_r <= d[15:0];
                    area_r  <= d[15:0] * d[31:16];
                    st_r    <= S_SIZE;
                  end else if (op_r == OP_HOST_TO_MEM) begin
                    wr_r       <= 1'b1;
                    cur_data_r <= d;
                    val_r      <= lin_addr;
                    rem_r      <= '0;
                    st_r       <= S_MOD;
                  end
                end else if (busy_r || is_poly_new) begin
                  // Polygon parameter word.
                  busy_r <= 1'b1;
                  op_r   <= eff_op;
                  case (eff_op)
                    OP_FLAT_QUAD: begin
                      if (eff_phase == 4'd0) begin
                        for (int i = 0; i < MAX_VERTICES; i++) begin
                          vs_r[i].r <= d[7:0];
                          vs_r[i].g <= d[15:8];
                          vs_r[i].b <= d[23:16];
                        end
                      end else if ({1'b0, ph_m1} < NV) begin
                        vs_r[ph_m1[VIW-1:0]].x <= d[15:0];
                        vs_r[ph_m1[VIW-1:0]].y <= d[31:16];
                      end
                    end
                    OP_TEX_QUAD: begin
                      if (eff_phase == 4'd0) begin
                        for (int i = 0; i < MAX_VERTICES; i++) begin
                          vs_r[i].r <= d[7:0];
                          vs_r[i].g <= d[15:8];
                          vs_r[i].b <= d[23:16];
                        end
                      end else if (eff_phase[0]) begin
                        if ({2'b0, tvi_r} < NV) begin
                          vs_r[tvi_r[VIW-1:0]].x <= d[15:0];
                          vs_r[tvi_r[VIW-1:0]].y <= d[31:16];
                        end
                      end else begin
                        if ({2'b0, tvi_r} < NV) begin
                          vs_r[tvi_r[VIW-1:0]].u <= d[7:0];
                          vs_r[tvi_r[VIW-1:0]].v <= d[15:8];
                        end
                        if (eff_phase == 4'd2) begin
                          pal_r <= d[31:16];
                        end else if (eff_phase == 4'd4) begin
                          page_r <= d[31:16];
                        end
                        tvi_r <= tvi_r + 3'd1;
                      end
                    end
                    default: begin
                      if ({2'b0, eff_phase[3:1]} < nvert) begin
                        if (!eff_phase[0]) begin
                          vs_r[eff_phase[VIW:1]].r <= d[7:0];
                          vs_r[eff_phase[VIW:1]].g <= d[15:8];
                          vs_r[eff_phase[VIW:1]].b <= d[23:16];
                        end else begin
                          vs_r[eff_phase[VIW:1]].x <= d[15:0];
                          vs_r[eff_phase[VIW:1]].y <= d[31:16];
                        end
                      end
                    end
                  endcase
                  phase_r <= ph_inc[3:0];
                  if (((eff_op == OP_FLAT_QUAD) && (ph_inc >= nvert + 5'd1)) ||
                      ((eff_op == OP_TEX_QUAD) && (ph_inc >= {nvert[3:0], 1'b1})) ||
                      ((eff_op != OP_FLAT_QUAD) && (eff_op != OP_TEX_QUAD) &&
                       (ph_inc >= {nvert[3:0], 1'b0}))) begin
                    busy_r    <= 1'b0;
                    phase_r   <= 4'd0;
                    tvi_r     <= 3'd0;
                    em_idx_r  <= '0;
                    em_last_r <= VIW'(nvert - 5'd1);
                    em_tex_r  <= (eff_op == OP_TEX_QUAD);
                    st_r      <= S_EMIT;
                  end
                end else if (is_xfer_new) begin
                  busy_r  <= 1'b1;
                  op_r    <= d[31:24];
                  phase_r <= 4'd0;
                end else if (d[31:24] == OP_DRAW_OFFSET) begin
                  out_r       <= '0;
                  out_r.kind  <= KIND_OFFSET;
                  out_r.pos_x <= {5'd0, d[10:0]};
                  out_r.pos_y <= {5'd0, d[21:11]};
                  out_r.last  <= 1'b1;
                  out_vld_r   <= 1'b1;
                end
              end
            endcase
          end
        end
        S_EMIT: begin
          // One stored vertex per transfer, the final one marked last.
          if (out_free) begin
            out_r               <= '0;
            out_r.kind          <= KIND_VERTEX;
            out_r.pos_x         <= em_v.x;
            out_r.pos_y         <= em_v.y;
            out_r.red           <= em_v.r;
            out_r.green         <= em_v.g;
            out_r.blue          <= em_v.b;
            out_r.tex_u         <= em_tex_r ? em_v.u : 8'd0;
            out_r.tex_v         <= em_tex_r ? em_v.v : 8'd0;
            out_r.palette_index <= em_tex_r ? pal_r : 16'd0;
            out_r.page_index    <= em_tex_r ? page_r : 16'd0;
            out_r.last          <= (em_idx_r == em_last_r);
            out_vld_r           <= 1'b1;
            em_idx_r            <= em_idx_r + VIW'(1);
            if (em_idx_r == em_last_r) begin
              st_r <= S_IDLE;
            end
          end
        end
        S_SIZE: begin
          // Word count of the rectangle: half its pixel count, rounded up.
          words_r <= words_init;
          if (words_init == 32'd0) begin
            busy_r  <= 1'b0;
            phase_r <= 4'd0;
          end else begin
            phase_r <= 4'd2;
          end
          st_r <= S_IDLE;
        end
        S_MOD: begin
          // Quotient estimate of the linear address by the store size.
          quo_r <= prod[VW+31:32];
          st_r  <= S_SUB;
        end
        S_SUB: begin
          // Remainder estimate, below twice the store size.
          diff_r <= val_r - quo_store;
          st_r   <= S_FIX;
        end
        S_FIX: begin
          // Final correction step of the remainder.
          rem_r <= (diff_r >= STORE_V) ? AW'(diff_r - STORE_V) : diff_r[AW-1:0];
          st_r  <= S_MEM0;
        end
        S_MEM0: begin
          st_r <= S_MEM1;
        end
        S_MEM1: begin
          hi_r <= mem_q_r;
          if (wr_r) begin
            walk_x_r <= row_wrap ? origin_r : wx_add;
            if (row_wrap) begin
              walk_y_r <= walk_y_r + 16'd1;
            end
            words_r <= words_dec;
            if (words_dec == 32'd0) begin
              busy_r   <= 1'b0;
              phase_r  <= 4'd0;
              origin_r <= 16'd0;
              width_r  <= 16'd0;
            end
            st_r <= S_IDLE;
          end else begin
            st_r <= S_MEM2;
          end
        end
        S_MEM2: begin
          if (out_free) begin
            out_r      <= '0;
            out_r.kind <= KIND_WORD;
            out_r.word <= {hi_r, mem_q_r};
            out_r.last <= 1'b1;
            out_vld_r  <= 1'b1;
            walk_x_r   <= row_wrap ? origin_r : wx_add;
            if (row_wrap) begin
              walk_y_r <= walk_y_r + 16'd1;
            end
            words_r <= words_dec;
            if (words_dec == 32'd0) begin
              busy_r  <= 1'b0;
              phase_r <= 4'd0;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.word          = out_r.word;
  assign out_ch.pos_x         = out_r.pos_x;
  assign out_ch.pos_y         = out_r.pos_y;
  assign out_ch.red           = out_r.red;
  assign out_ch.green         = out_r.green;
  assign out_ch.blue          = out_r.blue;
  assign out_ch.tex_u         = out_r.tex_u;
  assign out_ch.tex_v         = out_r.tex_v;
  assign out_ch.palette_index = out_r.palette_index;
  assign out_ch.page_index    = out_r.page_index;
  assign out_ch.last          = out_r.last;

endmodule

/* hdl/gpu_command_word_processor.sv */
// Command words, status reads and drawing-offset words are handled as they are taken; a
// polygon's vertices follow its final word at one transfer per cycle while the output is
// not stalled. A pixel word passes through address reduction by reciprocal multiplication
// (S_MOD, S_SUB, S_FIX), then the pixel-store states S_MEM0 and S_MEM1, plus S_MEM2 for
// a read; the store has a single port. Synchronous active-low reset clears control and
// vertex state; the pixel store is not cleared, and items are accepted right after reset.
module gpu_command_word_processor
  import cwp_pkg::*;
#(
  parameter int ROW_PIXELS   = 1024,
  parameter int ROWS         = 512,
  parameter int MAX_VERTICES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  cwp_in_if.sink    in_ch,
  cwp_out_if.source out_ch
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // Front end: classify and queue accepted items.
  cwp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back end: command execution, pixel store and results.
  cwp_back #(
    .ROW_PIXELS   (ROW_PIXELS),
    .ROWS         (ROWS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
